// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescape unit.
// Used by jsu_front, jsu_queue, jsu_back and the top level; no dependencies.
package jsu_pkg;

  // Queue between the decoder and the result serializer
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Byte codes of interest
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CTRL_BS      = 8'h08;
  localparam logic [7:0] CTRL_FF      = 8'h0C;
  localparam logic [7:0] CTRL_LF      = 8'h0A;
  localparam logic [7:0] CTRL_CR      = 8'h0D;
  localparam logic [7:0] CTRL_TAB     = 8'h09;

  // UTF-8 range limits
  localparam logic [15:0] UTF8_MAX1 = 16'h007F;
  localparam logic [15:0] UTF8_MAX2 = 16'h07FF;

  // Digit count once the fourth hex digit is due
  localparam logic [2:0] HEX_LAST = 3'd4;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_BAD_ESCAPE = 2'd1,
    ERR_BAD_HEX    = 2'd2,
    ERR_TRUNCATED  = 2'd3
  } err_kind_t;

  // One decoded transaction group: up to three results caused by one input byte
  typedef struct packed {
    logic [1:0]      count;     // number of results, 1 to 3
    logic [2:0][7:0] bytes;     // bytes[0] goes out first
    logic            has_byte;  // results carry decoded bytes
    logic            is_last;   // input byte closed the string
    err_kind_t       err;
  } packet_t;

  // Hex digit value; valid flag low for a non-hex byte
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== rtl/jsu_front.sv =====
// Front end of the JSON string unescape unit: escape decoder and UTF-8 encoder.
// Depends on jsu_pkg; pushes one packet per input byte that causes results.
module jsu_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             string_last,
  input  logic             q_full,
  output logic             push,
  output jsu_pkg::packet_t push_pkt
);
  import jsu_pkg::*;

  logic        escape_pending, escape_pending_next;
  logic [2:0]  hex_seen, hex_seen_next;
  logic [11:0] code_accum, code_accum_next;
  logic        drop, drop_next;

  logic        accept;
  logic [4:0]  hv;
  logic [15:0] cp;
  logic [1:0]  nb;
  logic [2:0][7:0] bytes;
  err_kind_t   err;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign hv       = hex_value(in_byte);
  assign cp       = {code_accum, hv[3:0]};

  // Decode one byte against the escape state
  always_comb begin
    escape_pending_next = escape_pending;
    hex_seen_next       = hex_seen;
    code_accum_next     = code_accum;
    drop_next           = drop;
    nb                  = 2'd0;
    bytes               = '0;
    err                 = ERR_NONE;

    if (drop) begin
      // discard
    end else if (hex_seen != 3'd0) begin
      if (string_last && hex_seen < HEX_LAST) begin
        err = ERR_TRUNCATED;
      end else if (!hv[4]) begin
        err = ERR_BAD_HEX;
      end else if (hex_seen == HEX_LAST) begin
        hex_seen_next   = 3'd0;
        code_accum_next = '0;
        if (cp <= UTF8_MAX1) begin
          nb       = 2'd1;
          bytes[0] = cp[7:0];
        end else if (cp <= UTF8_MAX2) begin
          nb       = 2'd2;
          bytes[0] = {3'b110, cp[10:6]};
          bytes[1] = {2'b10, cp[5:0]};
        end else begin
          nb       = 2'd3;
          bytes[0] = {4'b1110, cp[15:12]};
          bytes[1] = {2'b10, cp[11:6]};
          bytes[2] = {2'b10, cp[5:0]};
        end
      end else begin
        code_accum_next = {code_accum[7:0], hv[3:0]};
        hex_seen_next   = hex_seen + 3'd1;
      end
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      unique case (in_byte)
        CH_QUOTE:     begin nb = 2'd1; bytes[0] = CH_QUOTE;     end
        CH_BACKSLASH: begin nb = 2'd1; bytes[0] = CH_BACKSLASH; end
        CH_SLASH:     begin nb = 2'd1; bytes[0] = CH_SLASH;     end
        CH_B:         begin nb = 2'd1; bytes[0] = CTRL_BS;      end
        CH_F:         begin nb = 2'd1; bytes[0] = CTRL_FF;      end
        CH_N:         begin nb = 2'd1; bytes[0] = CTRL_LF;      end
        CH_R:         begin nb = 2'd1; bytes[0] = CTRL_CR;      end
        CH_T:         begin nb = 2'd1; bytes[0] = CTRL_TAB;     end
        CH_U: begin
          if (string_last) begin
            err = ERR_TRUNCATED;
          end else begin
            hex_seen_next   = 3'd1;
            code_accum_next = '0;
          end
        end
        default: err = ERR_BAD_ESCAPE;
      endcase
    end else if (in_byte == CH_BACKSLASH) begin
      escape_pending_next = 1'b1;
    end else begin
      nb       = 2'd1;
      bytes[0] = in_byte;
    end

    if (err != ERR_NONE) begin
      drop_next = 1'b1;
    end
    // End of string returns everything to its reset value
    if (string_last) begin
      escape_pending_next = 1'b0;
      hex_seen_next       = 3'd0;
      code_accum_next     = '0;
      drop_next           = 1'b0;
    end
  end

  // Build the packet for the queue
  always_comb begin
    push_pkt.bytes    = bytes;
    push_pkt.is_last  = string_last;
    push_pkt.err      = err;
    push_pkt.has_byte = (err == ERR_NONE) && (nb != 2'd0);
    push_pkt.count    = push_pkt.has_byte ? nb : 2'd1;
  end

  assign push = accept && ((err != ERR_NONE) || (nb != 2'd0) || string_last);

  // Advance decoder state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      hex_seen       <= 3'd0;
      code_accum     <= '0;
      drop           <= 1'b0;
    end else if (accept) begin
      escape_pending <= escape_pending_next;
      hex_seen       <= hex_seen_next;
      code_accum     <= code_accum_next;
      drop           <= drop_next;
    end
  end

`ifndef ASSERT_OFF
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && string_last |=> !escape_pending && hex_seen == 3'd0 && !drop)
    else $error("decoder state not cleared at end of string");
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    push && push_pkt.err != ERR_NONE |-> !push_pkt.has_byte && push_pkt.count == 2'd1)
    else $error("error packet carries bytes");
  a_hex_range: assert property (@(posedge clk) disable iff (rst)
    hex_seen <= HEX_LAST && !(escape_pending && hex_seen != 3'd0))
    else $error("escape state inconsistent");
`endif

endmodule

// ===== rtl/jsu_queue.sv =====
// Short packet queue between the decoder and the result serializer.
// Depends on jsu_pkg for the packet type and queue depth.
module jsu_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jsu_pkg::packet_t push_pkt,
  input  logic             pop,
  output jsu_pkg::packet_t head,
  output logic             empty,
  output logic             full
);
  import jsu_pkg::*;

  packet_t              entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_CW-1:0]  count;

  assign empty = (count == '0);
  assign full  = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  // Store pushed packets
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_pkt;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== rtl/jsu_back.sv =====
// Back end of the JSON string unescape unit: serializes packets into results.
// Depends on jsu_pkg; drives the registered output channel.
module jsu_back (
  input  logic             clk,
  input  logic             rst,
  input  jsu_pkg::packet_t head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             run_last,
  output logic             string_end,
  output logic [1:0]       error_kind
);
  import jsu_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       final_res;

  assign load      = !out_valid || !out_stall;
  assign final_res = (idx == head.count - 2'd1);
  assign pop       = load && !empty && final_res;

  // Step through the results of the head packet
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        idx <= final_res ? 2'd0 : idx + 2'd1;
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (load && !empty) begin
      out_byte   <= head.has_byte ? head.bytes[idx] : 8'd0;
      byte_valid <= head.has_byte;
      run_last   <= final_res;
      string_end <= final_res && head.is_last;
      error_kind <= head.err;
    end
  end

endmodule

// ===== rtl/json_string_unescape_unit.sv =====
// JSON string unescape unit: an accepted byte is queued, then its first result is loaded
// into the output register. Throughput one input byte per cycle while the queue has room;
// results leave one per cycle when out_stall is low, so a byte giving three UTF-8 bytes
// holds the output for three results; a four-packet queue buffers it before input stalls.
// Synchronous reset clears decoder state, queue pointers and the output valid.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
module json_string_unescape_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       string_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       run_last,
  output logic       string_end,
  output logic [1:0] error_kind
);
  import jsu_pkg::*;

  packet_t push_pkt;
  packet_t head;
  logic    push, pop, empty, full;

  // Decode incoming bytes
  jsu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .string_last (string_last),
    .q_full      (full),
    .push        (push),
    .push_pkt    (push_pkt)
  );

  // Buffer decoded packets
  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (push_pkt),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // Emit results one transaction at a time
  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .string_end (string_end),
    .error_kind (error_kind)
  );

endmodule
